### src/assert_macros.svh
// Assertion macros used by the RTL of the k-th available select block.
// Depends on nothing; each macro compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property with asynchronous active-low reset as the disable condition.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### src/kasr_pkg.sv
// Shared constants for the k-th available select and remove block.
// Depends on nothing; imported by kth_available_select_remove_top.
package kasr_pkg;

    // Field widths of the streams and the configuration register.
    localparam int SIZE_W      = 14;
    localparam int RANK_W      = 14;
    localparam int POS_W       = 14;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;

    // Default tree depth and the reset value of the size register.
    localparam int DEPTH_DEF   = 8192;
    localparam int SIZE_RESET  = 8192;

    // Operation codes carried in the input tuser bit.
    typedef enum logic
    {
        OP_RESTART = 1'b0,
        OP_SELECT  = 1'b1
    } op_t;

endpackage

### src/kth_available_select_remove_top.sv
// Top level of the k-th available select and remove block (Fenwick tree).
// Depends on kasr_pkg and assert_macros.svh.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser[0] is the operation
//   (0 restart, 1 select) and s_tdata[13:0] is the one-based rank. Every
//   accepted word gives exactly one result word on m_tvalid/m_tready, with
//   position and remaining count in m_tdata and the rank error in m_tuser.
//   The presence tree lives in one simple dual-port RAM of DEPTH entries.
//   A select descends the tree one level per cycle (about log2(n)+1 reads),
//   then walks the lowbit chain one entry per cycle (read, decrement, write
//   back). A bad rank is answered without touching the tree.
//   A restart rewrites entries 1..n, one per cycle. After reset the same
//   fill runs over min(8192, DEPTH) entries while s_tready stays low; no
//   result is sent. The size register may be written at any time but takes
//   effect at the next restart. On a receiver stall the next item is still
//   taken in, but its result waits in ST_RESULT (s_tready low) until the
//   output register drains.
module kth_available_select_remove_top #(
    parameter int DEPTH = kasr_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration: size_in_use.
    input  logic                           cfg_wr_en,
    input  logic [kasr_pkg::SIZE_W-1:0]    cfg_wr_data,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kasr_pkg::S_TDATA_W-1:0] s_tdata,   // [13:0] rank, [15:14] zero
    input  logic                           s_tuser,   // [0] operation
    // Output stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kasr_pkg::M_TDATA_W-1:0] m_tdata,   // [13:0] position, [27:14] remaining
    output logic                           m_tuser    // [0] rank_error
);
    import kasr_pkg::*;

    `include "assert_macros.svh"

    // Widths: counts up to DEPTH, RAM address, and a wider word for sums.
    localparam int PW  = $clog2(DEPTH + 1);
    localparam int AW  = $clog2(DEPTH);
    localparam int XW  = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
    localparam int RESET_N = (SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FILL,
        ST_DESC,
        ST_UPD,
        ST_RESULT
    } state_t;

    state_t          state_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [PW-1:0]   active_reg;
    logic [PW-1:0]   remaining_reg;
    logic [PW-1:0]   top_step_reg;
    logic [XW-1:0]   fill_cnt_reg;
    logic            reply_reg;
    logic [PW-1:0]   pos_reg;
    logic [PW-1:0]   k_reg;
    logic [PW-1:0]   step_reg;
    logic            in_range_reg;
    logic [PW-1:0]   x_reg;
    logic [PW-1:0]   res_pos_reg;
    logic            res_err_reg;
    logic            m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic            m_tuser_reg;

    // Tree RAM.
    logic [PW-1:0]   tree_mem [DEPTH];
    logic [PW-1:0]   mem_rd_data_reg;
    logic [AW-1:0]   mem_rd_addr;
    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    logic [PW-1:0]   mem_wr_data;

    logic            s_accept;
    op_t             in_op;
    logic [XW-1:0]   in_rank_x;
    logic [XW-1:0]   remaining_x;
    logic [XW-1:0]   active_x;
    logic            sel_bad;
    logic [XW-1:0]   size_x;
    logic [PW-1:0]   restart_n;
    logic            out_free;

    logic [XW-1:0]   next_sum;
    logic [XW-1:0]   rd_x;
    logic            take;
    logic [PW-1:0]   pos_take;
    logic [PW-1:0]   k_take;
    logic [PW-1:0]   step_half;
    logic [XW-1:0]   probe;
    logic            probe_ok;
    logic [PW-1:0]   found;

    logic [XW-1:0]   x_ext;
    logic [XW-1:0]   x_adv;
    logic            adv_ok;
    logic [PW-1:0]   dec_data;

    logic            fill_active;
    logic [XW-1:0]   fill_low;
    logic            fill_pow2;

    logic [XW-1:0]   res_pos_x;
    logic [XW-1:0]   res_rem_x;

    // Handshake and input decode.
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign in_op       = op_t'(s_tuser);
    assign in_rank_x   = XW'(s_tdata[RANK_W-1:0]);
    assign remaining_x = XW'(remaining_reg);
    assign active_x    = XW'(active_reg);
    assign sel_bad     = (in_rank_x == '0) || (in_rank_x > remaining_x);
    assign out_free    = !m_tvalid_reg || m_tready;

    // Active size for a restart saturates at the tree depth.
    assign size_x    = XW'(size_reg);
    assign restart_n = (size_x > DEPTH_X) ? PW'(DEPTH) : PW'(size_reg);

    // Descent step: compare the entry just read with the remaining rank.
    assign next_sum  = XW'(pos_reg) + XW'(step_reg);
    assign rd_x      = XW'(mem_rd_data_reg);
    assign take      = in_range_reg && (rd_x < XW'(k_reg));
    assign pos_take  = take ? next_sum[PW-1:0] : pos_reg;
    assign k_take    = take ? (k_reg - mem_rd_data_reg) : k_reg;
    assign step_half = step_reg >> 1;
    assign probe     = XW'(pos_take) + XW'(step_half);
    assign probe_ok  = (probe <= active_x);
    assign found     = pos_take + PW'(1);

    // Removal walk: decrement entry x and move up the lowbit chain.
    assign x_ext    = XW'(x_reg);
    assign x_adv    = x_ext + (x_ext & (~x_ext + XW'(1)));
    assign adv_ok   = (x_adv <= active_x);
    assign dec_data = (mem_rd_data_reg == '0) ? '0 : (mem_rd_data_reg - PW'(1));

    // Refill: entry i gets lowbit(i); the last power of two is the top step.
    assign fill_active = (fill_cnt_reg <= active_x);
    assign fill_low    = fill_cnt_reg & (~fill_cnt_reg + XW'(1));
    assign fill_pow2   = ((fill_cnt_reg & (fill_cnt_reg - XW'(1))) == '0);

    // RAM read address, chosen by the current phase.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  mem_rd_addr = AW'(top_step_reg - PW'(1));
            ST_DESC:
            begin
                if (step_half != '0)
                    mem_rd_addr = AW'(probe - XW'(1));
                else
                    mem_rd_addr = AW'(found - PW'(1));
            end
            ST_UPD:   mem_rd_addr = AW'(x_adv - XW'(1));
            default:  mem_rd_addr = '0;
        endcase
    end

    // RAM write port: fill sweep or decrement write-back.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(x_reg - PW'(1));
        mem_wr_data = dec_data;
        if (state_reg == ST_FILL)
        begin
            mem_wr_en   = fill_active;
            mem_wr_addr = AW'(fill_cnt_reg - XW'(1));
            mem_wr_data = PW'(fill_low);
        end
        else if (state_reg == ST_UPD)
        begin
            mem_wr_en = 1'b1;
        end
    end

    // Tree memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            tree_mem[mem_wr_addr] <= mem_wr_data;
        mem_rd_data_reg <= tree_mem[mem_rd_addr];
    end

    // Size register, written from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_W'(SIZE_RESET);
        else if (cfg_wr_en)
            size_reg <= cfg_wr_data;
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            active_reg    <= PW'(RESET_N);
            remaining_reg <= PW'(RESET_N);
            top_step_reg  <= '0;
            fill_cnt_reg  <= XW'(1);
            reply_reg     <= 1'b0;
            pos_reg       <= '0;
            k_reg         <= '0;
            step_reg      <= '0;
            in_range_reg  <= 1'b0;
            x_reg         <= '0;
            res_pos_reg   <= '0;
            res_err_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= 1'b0;
        end
        else
        begin
            // The result state reloads the output register itself.
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESULT))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        res_pos_reg <= '0;
                        if (in_op == OP_RESTART)
                        begin
                            res_err_reg   <= 1'b0;
                            active_reg    <= restart_n;
                            remaining_reg <= restart_n;
                            top_step_reg  <= '0;
                            fill_cnt_reg  <= XW'(1);
                            reply_reg     <= 1'b1;
                            state_reg     <= ST_FILL;
                        end
                        else if (sel_bad)
                        begin
                            res_err_reg <= 1'b1;
                            state_reg   <= ST_RESULT;
                        end
                        else
                        begin
                            // The first probe was issued this cycle at the top step.
                            res_err_reg   <= 1'b0;
                            remaining_reg <= remaining_reg - PW'(1);
                            k_reg         <= PW'(in_rank_x);
                            pos_reg       <= '0;
                            step_reg      <= top_step_reg;
                            in_range_reg  <= 1'b1;
                            state_reg     <= ST_DESC;
                        end
                    end
                end

                ST_FILL:
                begin
                    if (fill_active)
                    begin
                        if (fill_pow2)
                            top_step_reg <= PW'(fill_cnt_reg);
                        fill_cnt_reg <= fill_cnt_reg + XW'(1);
                    end
                    else if (reply_reg)
                        state_reg <= ST_RESULT;
                    else
                        state_reg <= ST_IDLE;
                end

                ST_DESC:
                begin
                    pos_reg      <= pos_take;
                    k_reg        <= k_take;
                    step_reg     <= step_half;
                    in_range_reg <= probe_ok;
                    if (step_half == '0)
                    begin
                        // Found; the first removal read was issued this cycle.
                        res_pos_reg <= found;
                        x_reg       <= found;
                        state_reg   <= ST_UPD;
                    end
                end

                ST_UPD:
                begin
                    if (adv_ok)
                        x_reg <= PW'(x_adv);
                    else
                        state_reg <= ST_RESULT;
                end

                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_TDATA_W'({res_rem_x[POS_W-1:0],
                                                    res_pos_x[POS_W-1:0]});
                        m_tuser_reg  <= res_err_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_pos_x = XW'(res_pos_reg);
    assign res_rem_x = XW'(remaining_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks on the sequencer.
    `ASSERT_CLK(a_remaining_bounded, clk, rst_n,
        remaining_reg <= active_reg, "remaining above active size")
    `ASSERT_CLK(a_top_bounded, clk, rst_n,
        top_step_reg <= active_reg, "top step above active size")
    `ASSERT_CLK(a_walk_in_range, clk, rst_n,
        (state_reg == ST_UPD) |-> ((x_reg != '0) && (x_reg <= active_reg)),
        "removal walk outside active range")
    `ASSERT_CLK(a_bad_rank_keeps_count, clk, rst_n,
        (s_accept && (in_op == OP_SELECT) && sel_bad) |=> $stable(remaining_reg),
        "bad rank changed remaining count")
    `ASSERT_NEVER(a_error_has_position, clk, rst_n,
        m_tvalid && m_tuser && (m_tdata[POS_W-1:0] != '0),
        "error result with nonzero position")

endmodule
